/* rtl/g2rr_pkg.sv */
// Shared types and constants for the 2bpp glyph row repacker.
// Used by g2rr_core, g2rr_fifo and glyph_2bpp_row_repacker; no dependencies.
package g2rr_pkg;

  // Output queue depth and count width (count must hold the depth itself).
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

  // Most results one item can cause.
  localparam int unsigned MaxResults = 2;

  typedef struct packed {
    logic [7:0] source_byte;
    logic [7:0] glyph_width;
    logic [7:0] glyph_height;
    logic       glyph_start;
  } item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       glyph_last;
  } result_t;

  // Results of one processed item, packed from slot 0 upward.
  typedef struct packed {
    logic [1:0] count;
    result_t    res1;
    result_t    res0;
  } step_t;

endpackage

/* rtl/g2rr_core.sv */
// Repacking datapath and position state: one item per step, up to two results.
// Depends on g2rr_pkg.
module g2rr_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  g2rr_pkg::item_t  item_i,
  output g2rr_pkg::step_t  step_o
);

  logic [5:0] acc_q, acc_d;
  logic [2:0] bits_q, bits_d;
  logic [5:0] bir_q, bir_d;
  logic [7:0] row_q, row_d;

  logic [5:0]  acc_c;
  logic [2:0]  bits_c;
  logic [5:0]  bir_c;
  logic [7:0]  row_c;
  logic [8:0]  stride_sum;
  logic [6:0]  stride;
  logic        row_end;
  logic [2:0]  npix;
  logic [3:0]  nbits;
  logic [7:0]  pix;
  logic [13:0] combined;
  logic [3:0]  total;
  logic [2:0]  rem;
  logic        have_byte;
  logic [7:0]  full_byte;
  logic [5:0]  acc_n;
  logic [2:0]  bits_n;
  logic        glyph_end;
  logic        flush;
  logic [7:0]  flush_byte;
  logic        size_zero;

  always_comb begin
    // glyph_start clears position before the byte is used
    acc_c  = item_i.glyph_start ? 6'd0 : acc_q;
    bits_c = item_i.glyph_start ? 3'd0 : bits_q;
    bir_c  = item_i.glyph_start ? 6'd0 : bir_q;
    row_c  = item_i.glyph_start ? 8'd0 : row_q;

    size_zero  = (item_i.glyph_width == 8'd0) || (item_i.glyph_height == 8'd0);
    stride_sum = {1'b0, item_i.glyph_width} + 9'd3;
    stride     = stride_sum[8:2];
    row_end    = ({1'b0, bir_c} + 7'd1) >= stride;

    if (row_end && (item_i.glyph_width[1:0] != 2'd0)) begin
      npix = {1'b0, item_i.glyph_width[1:0]};
    end else begin
      npix = 3'd4;
    end
    nbits    = {npix, 1'b0};
    pix      = item_i.source_byte >> (4'd8 - nbits);
    combined = ({8'd0, acc_c} << nbits) | {6'd0, pix};
    total    = {1'b0, bits_c} + nbits;

    have_byte = (total >= 4'd8);
    rem       = 3'(total - 4'd8);
    full_byte = 8'(combined >> rem);
    if (have_byte) begin
      acc_n  = 6'(combined & ((14'd1 << rem) - 14'd1));
      bits_n = rem;
    end else begin
      acc_n  = combined[5:0];
      bits_n = total[2:0];
    end

    glyph_end = 1'b0;
    bir_d     = bir_c + 6'd1;
    row_d     = row_c;
    if (row_end) begin
      bir_d = 6'd0;
      if (({1'b0, row_c} + 9'd1) >= {1'b0, item_i.glyph_height}) begin
        glyph_end = 1'b1;
      end else begin
        row_d = row_c + 8'd1;
      end
    end
    acc_d  = acc_n;
    bits_d = bits_n;

    // leftover bits go out left-aligned, zero-filled below
    flush      = glyph_end && (bits_n != 3'd0);
    flush_byte = {2'd0, acc_n} << (4'd8 - {1'b0, bits_n});

    if (glyph_end) begin
      acc_d  = 6'd0;
      bits_d = 3'd0;
      bir_d  = 6'd0;
      row_d  = 8'd0;
    end

    step_o = '0;
    if (have_byte) begin
      step_o.res0 = '{packed_byte: full_byte, glyph_last: glyph_end && !flush};
      step_o.res1 = '{packed_byte: flush_byte, glyph_last: 1'b1};
      step_o.count = flush ? 2'd2 : 2'd1;
    end else if (flush) begin
      step_o.res0  = '{packed_byte: flush_byte, glyph_last: 1'b1};
      step_o.count = 2'd1;
    end

    // zero size: byte ignored, only the start clearing sticks
    if (size_zero) begin
      step_o.count = 2'd0;
      acc_d        = acc_c;
      bits_d       = bits_c;
      bir_d        = bir_c;
      row_d        = row_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      bits_q <= '0;
      bir_q  <= '0;
      row_q  <= '0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      bits_q <= bits_d;
      bir_q  <= bir_d;
      row_q  <= row_d;
    end
  end

endmodule

/* rtl/g2rr_fifo.sv */
// Small result queue: takes up to two results per cycle, hands out one while the consumer is ready.
// Depends on g2rr_pkg.
module g2rr_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  g2rr_pkg::step_t   push_i,
  input  logic              push_en_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output g2rr_pkg::result_t data_o
);

  localparam int unsigned Aw = g2rr_pkg::QueueAw;
  localparam int unsigned Cw = g2rr_pkg::QueueCw;

  g2rr_pkg::result_t mem_q [g2rr_pkg::QueueDepth];

  logic [Aw-1:0] head_q, head_d;
  logic [Aw-1:0] tail_q, tail_d;
  logic [Cw-1:0] count_q, count_d;
  logic [1:0]    push_n;
  logic          pop;
  logic [Aw-1:0] tail_p1;

  always_comb begin
    push_n  = push_en_i ? push_i.count : 2'd0;
    pop     = valid_o && ready_i;
    tail_p1 = tail_q + Aw'(1);
    head_d  = pop ? head_q + Aw'(1) : head_q;
    tail_d  = tail_q + Aw'(push_n);
    count_d = count_q + Cw'(push_n) - Cw'(pop);
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[head_q];
  assign room_o  = (count_q <= Cw'(g2rr_pkg::QueueDepth - g2rr_pkg::MaxResults));

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[tail_q] <= push_i.res0;
    end
    if (push_n == 2'd2) begin
      mem_q[tail_p1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

/* rtl/glyph_2bpp_row_repacker.sv */
// Top level of the 2bpp glyph row repacker: input register, repack core, result queue.
// Depends on g2rr_pkg, g2rr_core and g2rr_fifo.
//
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+-----
//  in      | in_valid_i/in_ready_o, source_byte_i, glyph_width_i, | in
//          | glyph_height_i, glyph_start_i                        |
//  out     | out_valid_o/out_ready_i, packed_byte_o, glyph_last_o | out
//
// One source byte per clock is taken while the queue has room; a byte's results
// (zero, one, or two at glyph end) are written into the result queue when the
// byte leaves the input register, and show on the output from there.
// The input register feeds the core, which writes a four-entry result queue;
// the register advances only while the queue has room for two results.
// Reset (rst_ni low, asynchronous) empties the input register and the queue
// and clears the accumulator and row/byte position.
// An output stall backs up through the queue into in_ready_o.
module glyph_2bpp_row_repacker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] source_byte_i,
  input  logic [7:0] glyph_width_i,
  input  logic [7:0] glyph_height_i,
  input  logic       glyph_start_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] packed_byte_o,
  output logic       glyph_last_o
);

  // input register
  logic              in_valid_q;
  g2rr_pkg::item_t   item_q;

  logic              room;
  logic              advance;
  g2rr_pkg::step_t   step;
  g2rr_pkg::result_t head;

  // the held item moves into the core/queue once two result slots are free
  assign advance    = in_valid_q && room;
  assign in_ready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{source_byte:  source_byte_i,
                  glyph_width:  glyph_width_i,
                  glyph_height: glyph_height_i,
                  glyph_start:  glyph_start_i};
    end
  end

  // repack datapath; state updates only when the item leaves the register
  g2rr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .step_o (step)
  );

  // results wait here for the consumer
  g2rr_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (step),
    .push_en_i (advance),
    .room_o    (room),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .data_o    (head)
  );

  assign packed_byte_o = head.packed_byte;
  assign glyph_last_o  = head.glyph_last;

endmodule
